// ===== hdl/fsc_pkg.sv =====
`default_nettype none
package fsc_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIV_W      = 32 + FRAC_BITS;
   localparam int ACC_W      = 67;
   localparam int PROD_W     = 66;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W      = $clog2(DIV_W + 1);
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_EXTRACT = 2'd1,
      ACT_TEST    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RAW_W, S_RAW_C, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_SQRT_WAIT,
      S_DIV, S_DIV_WAIT, S_RAW_STORE, S_T_MUL, S_T_ACC, S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } unit_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_rsp_type;

endpackage
`default_nettype wire

// ===== hdl/frustum_sphere_culler.sv =====
`default_nettype none
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser action, tdata element and sphere fields
// rsp       out  rsp_tvalid/rsp_tready  tdata visible, degenerate
// csr       in   csr_we                 csr_wdata far_plane_mode
//
// A load writes one matrix element and responds when accepted. A sphere test runs
// at most five planes of four terms: three from the shared multiplier and one from
// offset plus radius, each into the accumulator. An extraction uses the bit-serial
// root and divide unit: one root per plane, one divide per coefficient. One item
// at a time; the next item is taken only once the output register is empty or
// being read. Reset is synchronous and clears matrix, planes and mode.
module frustum_sphere_culler (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // tuser: action[1:0]
   input  wire  [1:0]                          req_tuser,
   // tdata: element_index[3:0], element_value[35:4], center_x[67:36],
   //        center_y[99:68], center_z[131:100], radius[163:132], zero fill
   input  wire  [fsc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // tdata: visible[0], degenerate[1], zero fill
   output logic [fsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire                                 csr_we,
   input  wire                                 csr_wdata
);
   import fsc_pkg::*;

   state_type          state_ff, state_in;
   logic [2:0]         p_ff, p_in;
   logic [1:0]         k_ff, k_in;
   logic signed [31:0] cx_ff, cy_ff, cz_ff, rad_ff;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [31:0] raw_ff [4];
   logic signed [31:0] mtx_ff [16];
   logic signed [31:0] pln_ff [20];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [31:0]        len_ff, len_in;
   logic               degen_ff, degen_in, vis_ff, vis_in;
   logic               mode_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_vis_ff, rsp_vis_in, rsp_degen_ff, rsp_degen_in;

   logic               accept, push, out_free;
   action_type         act;
   logic [1:0]         col;
   logic               only_col, minus;
   logic [3:0]         rd_idx;
   logic signed [31:0] rd_val, pl_val, raw_k;
   logic signed [32:0] vsum, dr_sum;
   logic signed [31:0] vsat, qsat;
   logic [31:0]        mag_k;
   logic signed [32:0] mul_a, mul_b;
   logic [DIV_W-1:0]   q;
   logic               raw_we, pln_we;
   logic signed [31:0] pln_wval;
   logic [4:0]         pln_idx;
   logic               acc_le0;

   unit_req_type       unit_req;
   unit_rsp_type       unit_rsp;
   logic [63:0]        unit_a, unit_res;

   fsc_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .op_a     (unit_a),
      .op_b     (len_ff),
      .unit_rsp (unit_rsp),
      .result   (unit_res)
   );

   assign act        = action_type'(req_tuser);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == S_IDLE) & out_free;
   assign accept     = req_tvalid & req_tready;

   // plane geometry: left, right, bottom, top use x,x,y,y; far uses z
   assign col      = (p_ff == 3'd4) ? 2'd2 : p_ff[2:1];
   assign minus    = p_ff[0] | (p_ff == 3'd4);
   assign only_col = (p_ff == 3'd4) & mode_ff;
   assign rd_idx   = (state_ff == S_RAW_W) ? {k_ff, 2'd3} : {k_ff, col};
   assign rd_val   = mtx_ff[rd_idx];
   assign pln_idx  = {p_ff, k_ff};
   assign pl_val   = pln_ff[pln_idx];
   assign raw_k    = raw_ff[k_ff];
   assign mag_k    = raw_k[31] ? 32'(-raw_k) : 32'(raw_k);
   assign q        = unit_res[DIV_W-1:0];

   always_comb begin
      if (only_col)   vsum = 33'(rd_val);
      else if (minus) vsum = 33'(tmp_ff) - 33'(rd_val);
      else            vsum = 33'(tmp_ff) + 33'(rd_val);
      if (vsum[32] != vsum[31]) vsat = vsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else                      vsat = vsum[31:0];
      if (raw_k[31]) qsat = (q > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                        : -$signed(q[31:0]);
      else           qsat = (q > DIV_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                        : $signed(q[31:0]);
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == S_SQ_MUL) begin
         mul_a = $signed({1'b0, mag_k});
         mul_b = $signed({1'b0, mag_k});
      end else begin
         mul_a = 33'(pl_val);
         case (k_ff)
            2'd0:    mul_b = 33'(cx_ff);
            2'd1:    mul_b = 33'(cy_ff);
            default: mul_b = 33'(cz_ff);
         endcase
      end
   end

   assign dr_sum  = 33'(pl_val) + 33'(rad_ff);
   assign acc_in  = acc_ff + ACC_W'(prod_ff);
   assign acc_le0 = acc_in[ACC_W-1] | (acc_in == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:
            if (accept) begin
               if (act == ACT_EXTRACT)   state_in = S_RAW_W;
               else if (act == ACT_TEST) state_in = S_T_MUL;
            end
         S_RAW_W:  state_in = S_RAW_C;
         S_RAW_C:  state_in = (k_ff == 2'd3) ? S_SQ_MUL : S_RAW_W;
         S_SQ_MUL: state_in = S_SQ_ACC;
         S_SQ_ACC: state_in = (k_ff == 2'd2) ? S_SQRT : S_SQ_MUL;
         S_SQRT:   state_in = S_SQRT_WAIT;
         S_SQRT_WAIT:
            if (unit_rsp.done) state_in = (unit_res == '0) ? S_RAW_STORE : S_DIV;
         S_DIV:    state_in = S_DIV_WAIT;
         S_DIV_WAIT:
            if (unit_rsp.done) begin
               if (k_ff != 2'd3)      state_in = S_DIV;
               else if (p_ff == 3'd4) state_in = S_DONE;
               else                   state_in = S_RAW_W;
            end
         S_RAW_STORE:
            if (k_ff == 2'd3) state_in = (p_ff == 3'd4) ? S_DONE : S_RAW_W;
         S_T_MUL:  state_in = S_T_ACC;
         S_T_ACC:
            if (k_ff == 2'd3 && (acc_le0 || p_ff == 3'd4)) state_in = S_DONE;
            else                                            state_in = S_T_MUL;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      p_in         = p_ff;
      k_in         = k_ff;
      tmp_in       = tmp_ff;
      prod_in      = prod_ff;
      len_in       = len_ff;
      degen_in     = degen_ff;
      vis_in       = vis_ff;
      raw_we       = 1'b0;
      pln_we       = 1'b0;
      pln_wval     = raw_k;
      unit_req     = '0;
      unit_a       = {32'd0, mag_k} << FRAC_BITS;
      push         = 1'b0;
      rsp_vis_in   = rsp_vis_ff;
      rsp_degen_in = rsp_degen_ff;
      case (state_ff)
         S_IDLE:
            if (accept) begin
               p_in     = '0;
               k_in     = '0;
               degen_in = 1'b0;
               vis_in   = 1'b0;
               if (act == ACT_LOAD || act == ACT_NONE) begin
                  push         = 1'b1;
                  rsp_vis_in   = 1'b0;
                  rsp_degen_in = 1'b0;
               end
            end
         S_RAW_W: tmp_in = rd_val;
         S_RAW_C: begin
            raw_we = 1'b1;
            k_in   = k_ff + 1'b1;
         end
         S_SQ_MUL: prod_in = mul_a * mul_b;
         S_SQ_ACC: k_in = (k_ff == 2'd2) ? 2'd0 : k_ff + 1'b1;
         S_SQRT: begin
            unit_req.start     = 1'b1;
            unit_req.sqrt_mode = 1'b1;
            unit_a             = acc_ff[63:0];
         end
         S_SQRT_WAIT:
            if (unit_rsp.done) len_in = unit_res[31:0];
         S_DIV: unit_req.start = 1'b1;
         S_DIV_WAIT:
            if (unit_rsp.done) begin
               pln_we   = 1'b1;
               pln_wval = qsat;
               k_in     = k_ff + 1'b1;
               if (k_ff == 2'd3 && p_ff != 3'd4) p_in = p_ff + 1'b1;
            end
         S_RAW_STORE: begin
            pln_we   = 1'b1;
            degen_in = 1'b1;
            k_in     = k_ff + 1'b1;
            if (k_ff == 2'd3 && p_ff != 3'd4) p_in = p_ff + 1'b1;
         end
         S_T_MUL:
            if (k_ff == 2'd3) prod_in = PROD_W'(dr_sum) <<< FRAC_BITS;
            else              prod_in = mul_a * mul_b;
         S_T_ACC: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               if (acc_le0)           vis_in = 1'b0;
               else if (p_ff == 3'd4) vis_in = 1'b1;
               else                   p_in = p_ff + 1'b1;
            end
         end
         S_DONE:
            if (out_free) begin
               push         = 1'b1;
               rsp_vis_in   = vis_ff;
               rsp_degen_in = degen_ff;
            end
         default: ;
      endcase
   end

   assign rsp_valid_in = push | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
      len_ff  <= len_in;
      vis_ff  <= vis_in;
      degen_ff <= degen_in;
      rsp_vis_ff   <= rsp_vis_in;
      rsp_degen_ff <= rsp_degen_in;
      if (raw_we) raw_ff[k_ff] <= vsat;
      // accumulator clears at the start of every plane
      if ((state_ff == S_IDLE) || (state_ff == S_RAW_W && k_ff == 2'd0) ||
          (state_ff == S_T_ACC && k_ff == 2'd3))
         acc_ff <= '0;
      else if (state_ff == S_SQ_ACC || state_ff == S_T_ACC)
         acc_ff <= acc_in;
      if (accept) begin
         cx_ff  <= $signed(req_tdata[67:36]);
         cy_ff  <= $signed(req_tdata[99:68]);
         cz_ff  <= $signed(req_tdata[131:100]);
         rad_ff <= $signed(req_tdata[163:132]);
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         p_ff         <= '0;
         k_ff         <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) mtx_ff[i] <= '0;
         for (int i = 0; i < 20; i++) pln_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) mode_ff <= csr_wdata;
         if (accept && act == ACT_LOAD)
            mtx_ff[req_tdata[3:0]] <= $signed(req_tdata[35:4]);
         if (pln_we) pln_ff[pln_idx] <= pln_wval;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_degen_ff, rsp_vis_ff};

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE) || rsp_valid_ff)
      else $error("accepted item neither in work nor delivered");

   a_unit_done_expected: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == S_SQRT_WAIT) || (state_ff == S_DIV_WAIT))
      else $error("root/divide result arrived while not awaited");

   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      unit_req.start |-> !unit_rsp.busy)
      else $error("root/divide unit restarted while busy");

   a_plane_in_range: assert property (@(posedge clock) disable iff (reset)
      p_ff <= 3'd4)
      else $error("plane counter out of range");

endmodule
`default_nettype wire

// ===== hdl/fsc_root_div.sv =====
`default_nettype none
module fsc_root_div (
   input  wire                      clock,
   input  wire                      reset,
   input  wire fsc_pkg::unit_req_type unit_req,
   input  wire  [63:0]              op_a,
   input  wire  [31:0]              op_b,
   output fsc_pkg::unit_rsp_type    unit_rsp,
   output logic [63:0]              result
);
   import fsc_pkg::*;

   logic [63:0]      shift_ff, shift_in;
   logic [33:0]      rem_ff, rem_in;
   logic [63:0]      q_ff, q_in;
   logic [31:0]      den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sqrt_ff, sqrt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [35:0]      rem_sh, trial;
   logic [36:0]      diff;
   logic             ge;

   // one restoring step: shared subtract and compare for root and quotient
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff, shift_ff[63:62]};
         trial  = {2'b00, q_ff[31:0], 2'b01};
      end else begin
         rem_sh = {1'b0, rem_ff, shift_ff[63]};
         trial  = {4'b0000, den_ff};
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
      ge   = ~diff[36];
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      sqrt_in  = sqrt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (unit_req.start) begin
         sqrt_in = unit_req.sqrt_mode;
         den_in  = op_b;
         rem_in  = '0;
         q_in    = '0;
         busy_in = 1'b1;
         if (unit_req.sqrt_mode) begin
            shift_in = op_a;
            cnt_in   = CNT_W'(SQRT_STEPS);
         end else begin
            shift_in = {op_a[DIV_W-1:0], {(64-DIV_W){1'b0}}};
            cnt_in   = CNT_W'(DIV_W);
         end
      end else if (busy_ff) begin
         rem_in   = ge ? diff[33:0] : rem_sh[33:0];
         q_in     = {q_ff[62:0], ge};
         shift_in = sqrt_ff ? {shift_ff[61:0], 2'b00} : {shift_ff[62:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      den_ff   <= den_in;
      sqrt_ff  <= sqrt_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign unit_rsp.busy = busy_ff;
   assign unit_rsp.done = done_ff;
   assign result        = q_ff;

endmodule
`default_nettype wire
